@@ sv/qvr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package qvr_pkg;

    // default number format: Q1.14 in 16 bits
    localparam int COMPONENT_WIDTH = 16;
    localparam int FRACTION_BITS   = 14;

    // control that travels with each item down the pipe
    typedef struct packed {
        logic valid;
        logic sat;
    } t_ctl;

endpackage

`default_nettype wire

@@ sv/qvr_mul_stage.sv @@
`timescale 1ns / 1ps
`default_nettype none

// All sixteen cross products a[i]*b[j] of two quaternions, registered.
module qvr_mul_stage #(
    parameter int A_WIDTH = qvr_pkg::COMPONENT_WIDTH,
    parameter int B_WIDTH = qvr_pkg::COMPONENT_WIDTH
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire logic signed [A_WIDTH-1:0]      i_a [4],
    input  wire logic signed [B_WIDTH-1:0]      i_b [4],
    input  wire qvr_pkg::t_ctl                  i_ctl,
    output logic signed [A_WIDTH+B_WIDTH-1:0]   o_p [4][4],
    output qvr_pkg::t_ctl                       o_ctl
);

    localparam int P_WIDTH = A_WIDTH + B_WIDTH;

    logic signed [P_WIDTH-1:0] r_p [4][4];
    logic signed [P_WIDTH-1:0] n_p [4][4];
    qvr_pkg::t_ctl             r_ctl;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                n_p[i][j] = P_WIDTH'(i_a[i]) * P_WIDTH'(i_b[j]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    // payload: no reset
    always_ff @(posedge i_clk) begin
        r_p <= n_p;
    end

    assign o_p   = r_p;
    assign o_ctl = r_ctl;

endmodule

`default_nettype wire

@@ sv/qvr_sum_stage.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Hamilton sign pattern over the cross products, round half up, saturate.
module qvr_sum_stage #(
    parameter int P_WIDTH         = 2 * qvr_pkg::COMPONENT_WIDTH,
    parameter int COMPONENT_WIDTH = qvr_pkg::COMPONENT_WIDTH,
    parameter int FRACTION_BITS   = qvr_pkg::FRACTION_BITS
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire logic signed [P_WIDTH-1:0]      i_p [4][4],
    input  wire qvr_pkg::t_ctl                  i_ctl,
    output logic signed [COMPONENT_WIDTH-1:0]   o_q [4],
    output qvr_pkg::t_ctl                       o_ctl
);

    localparam int S_WIDTH = P_WIDTH + 3;
    localparam logic signed [S_WIDTH-1:0] HALF = S_WIDTH'(1) << (FRACTION_BITS - 1);
    localparam logic signed [S_WIDTH-1:0] SMAX =
        (S_WIDTH'(1) << (COMPONENT_WIDTH - 1)) - S_WIDTH'(1);
    localparam logic signed [S_WIDTH-1:0] SMIN = -SMAX - S_WIDTH'(1);

    logic signed [S_WIDTH-1:0]         sum [4];
    logic signed [S_WIDTH-1:0]         rnd [4];
    logic signed [COMPONENT_WIDTH-1:0] n_q [4];
    logic                              n_sat;
    logic signed [COMPONENT_WIDTH-1:0] r_q [4];
    qvr_pkg::t_ctl                     r_ctl;

    always_comb begin
        sum[0] = S_WIDTH'(i_p[0][0]) - S_WIDTH'(i_p[1][1])
               - S_WIDTH'(i_p[2][2]) - S_WIDTH'(i_p[3][3]);
        sum[1] = S_WIDTH'(i_p[0][1]) + S_WIDTH'(i_p[1][0])
               + S_WIDTH'(i_p[2][3]) - S_WIDTH'(i_p[3][2]);
        sum[2] = S_WIDTH'(i_p[0][2]) - S_WIDTH'(i_p[1][3])
               + S_WIDTH'(i_p[2][0]) + S_WIDTH'(i_p[3][1]);
        sum[3] = S_WIDTH'(i_p[0][3]) + S_WIDTH'(i_p[1][2])
               - S_WIDTH'(i_p[2][1]) + S_WIDTH'(i_p[3][0]);
        n_sat  = i_ctl.sat;
        for (int k = 0; k < 4; k++) begin
            // floor shift after adding half an lsb
            rnd[k] = (sum[k] + HALF) >>> FRACTION_BITS;
            if (rnd[k] > SMAX) begin
                n_q[k] = SMAX[COMPONENT_WIDTH-1:0];
                n_sat  = 1'b1;
            end else if (rnd[k] < SMIN) begin
                n_q[k] = SMIN[COMPONENT_WIDTH-1:0];
                n_sat  = 1'b1;
            end else begin
                n_q[k] = rnd[k][COMPONENT_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl.valid <= i_ctl.valid;
            r_ctl.sat   <= n_sat & i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_q   = r_q;
    assign o_ctl = r_ctl;

endmodule

`default_nettype wire

@@ sv/quaternion_vector_rotation.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Quaternion rotation o = r * v * conj(r) in signed fixed point (Q1.14 by
// default). An item is taken on any cycle with start high and busy low;
// busy is low whenever the block is out of reset, so one item per clock is
// sustained. The result leaves the last register of the pipeline below, held for one
// cycle with o_valid high. There is no back-pressure: the receiver must
// take every result in the cycle it is shown. Each product component is
// summed exactly, rounded half up and saturated; o_saturated flags any
// clipping, in the middle product or in the final result.
//
// Pipeline (one register after each step):
//   1  sixteen products r[i]*v[j]
//   2  sum, round, saturate -> m
//   3  sixteen products m[i]*conj(r)[j] (conjugate formed exactly, one bit wider)
//   4  sum, round, saturate -> outputs
// The registers sit after the two multiplier rows and the two adder rows.
module quaternion_vector_rotation #(
    parameter int COMPONENT_WIDTH = qvr_pkg::COMPONENT_WIDTH,
    parameter int FRACTION_BITS   = qvr_pkg::FRACTION_BITS
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                start,
    output logic                               busy,
    input  wire logic signed [COMPONENT_WIDTH-1:0] i_rot_w,
    input  wire logic signed [COMPONENT_WIDTH-1:0] i_rot_x,
    input  wire logic signed [COMPONENT_WIDTH-1:0] i_rot_y,
    input  wire logic signed [COMPONENT_WIDTH-1:0] i_rot_z,
    input  wire logic signed [COMPONENT_WIDTH-1:0] i_vec_w,
    input  wire logic signed [COMPONENT_WIDTH-1:0] i_vec_x,
    input  wire logic signed [COMPONENT_WIDTH-1:0] i_vec_y,
    input  wire logic signed [COMPONENT_WIDTH-1:0] i_vec_z,
    output logic                               o_valid,
    output logic signed [COMPONENT_WIDTH-1:0]  o_out_w,
    output logic signed [COMPONENT_WIDTH-1:0]  o_out_x,
    output logic signed [COMPONENT_WIDTH-1:0]  o_out_y,
    output logic signed [COMPONENT_WIDTH-1:0]  o_out_z,
    output logic                               o_saturated
);

    localparam int W   = COMPONENT_WIDTH;
    localparam int PW1 = 2 * W;        // r * v products
    localparam int CW  = W + 1;        // conjugate components
    localparam int PW2 = W + CW;       // m * conj(r) products

    logic signed [W-1:0]   rot [4];
    logic signed [W-1:0]   vec [4];
    qvr_pkg::t_ctl         in_ctl;

    logic signed [PW1-1:0] p1 [4][4];
    qvr_pkg::t_ctl         ctl1;
    logic signed [W-1:0]   m [4];
    qvr_pkg::t_ctl         ctl2;
    logic signed [PW2-1:0] p2 [4][4];
    qvr_pkg::t_ctl         ctl3;
    logic signed [W-1:0]   q [4];
    qvr_pkg::t_ctl         ctl4;

    // rotor rides alongside the first two stages
    logic signed [W-1:0]   r_rot_d1 [4];
    logic signed [W-1:0]   r_rot_d2 [4];
    logic signed [CW-1:0]  rc [4];

    assign busy = ~i_rst_n;

    assign rot = '{i_rot_w, i_rot_x, i_rot_y, i_rot_z};
    assign vec = '{i_vec_w, i_vec_x, i_vec_y, i_vec_z};

    assign in_ctl.valid = start & ~busy;
    assign in_ctl.sat   = 1'b0;

    always_ff @(posedge i_clk) begin
        r_rot_d1 <= rot;
        r_rot_d2 <= r_rot_d1;
    end

    // wide negation: the most negative code does not wrap
    always_comb begin
        rc[0] = CW'(r_rot_d2[0]);
        for (int k = 1; k < 4; k++) begin
            rc[k] = -CW'(r_rot_d2[k]);
        end
    end

    qvr_mul_stage #(
        .A_WIDTH (W),
        .B_WIDTH (W)
    ) u_mul_rv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_a     (rot),
        .i_b     (vec),
        .i_ctl   (in_ctl),
        .o_p     (p1),
        .o_ctl   (ctl1)
    );

    qvr_sum_stage #(
        .P_WIDTH         (PW1),
        .COMPONENT_WIDTH (W),
        .FRACTION_BITS   (FRACTION_BITS)
    ) u_sum_rv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_p     (p1),
        .i_ctl   (ctl1),
        .o_q     (m),
        .o_ctl   (ctl2)
    );

    qvr_mul_stage #(
        .A_WIDTH (W),
        .B_WIDTH (CW)
    ) u_mul_mc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_a     (m),
        .i_b     (rc),
        .i_ctl   (ctl2),
        .o_p     (p2),
        .o_ctl   (ctl3)
    );

    qvr_sum_stage #(
        .P_WIDTH         (PW2),
        .COMPONENT_WIDTH (W),
        .FRACTION_BITS   (FRACTION_BITS)
    ) u_sum_mc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_p     (p2),
        .i_ctl   (ctl3),
        .o_q     (q),
        .o_ctl   (ctl4)
    );

    assign o_valid     = ctl4.valid;
    assign o_saturated = ctl4.sat;
    assign o_out_w     = q[0];
    assign o_out_x     = q[1];
    assign o_out_y     = q[2];
    assign o_out_z     = q[3];

endmodule

`default_nettype wire

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;

    localparam int CW = qvr_pkg::COMPONENT_WIDTH;
    localparam int FB = qvr_pkg::FRACTION_BITS;

    // saturation limits and rounding offset at the block's widths
    localparam longint SAT_HI = (longint'(1) << (CW - 1)) - 1;
    localparam longint SAT_LO = -SAT_HI - 1;
    localparam longint HALF_LSB = longint'(1) << (FB - 1);

    // Q1.14 handy values
    localparam int ONE = 1 << FB;
    localparam int COS45 = 11585;
    localparam int ROOT2 = 23170;

    // pipeline depth plus margin, used for the final settle
    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_ITEMS = 1800;

    typedef logic signed [CW-1:0] comp_t;
    typedef comp_t quat_t [4];

    typedef struct {
        comp_t c[4];
        logic  sat;
    } rotated_t;

    // Expected rotated quaternions, in order of acceptance. Each accepted
    // item is turned into r * v * conj(r) here and checked against the
    // output stream in order.
    class rotation_scoreboard;
        rotated_t expected_q[$];
        int errors;

        function new();
            errors = 0;
        endfunction

        task report(string msg);
            $display("%0t ns: %s", $time, msg);
            errors++;
        endtask

        // round half up at the binary point, then clip to the component range
        function longint round_sat(longint s, inout bit clipped);
            longint q;
            q = (s + HALF_LSB) >>> FB;
            if (q > SAT_HI) begin
                clipped = 1'b1;
                q = SAT_HI;
            end else if (q < SAT_LO) begin
                clipped = 1'b1;
                q = SAT_LO;
            end
            return q;
        endfunction

        // Hamilton product p = a * b, each component summed exactly first
        function void hamilton(input longint a[4], input longint b[4],
                               output longint p[4], inout bit clipped);
            longint s[4];
            s[0] = a[0]*b[0] - a[1]*b[1] - a[2]*b[2] - a[3]*b[3];
            s[1] = a[0]*b[1] + a[1]*b[0] + a[2]*b[3] - a[3]*b[2];
            s[2] = a[0]*b[2] - a[1]*b[3] + a[2]*b[0] + a[3]*b[1];
            s[3] = a[0]*b[3] + a[1]*b[2] - a[2]*b[1] + a[3]*b[0];
            for (int i = 0; i < 4; i++)
                p[i] = round_sat(s[i], clipped);
        endfunction

        function void note_item(quat_t rot, quat_t vec);
            longint r[4], v[4], rc[4], m[4], o[4];
            bit clipped;
            rotated_t want;
            clipped = 1'b0;
            for (int i = 0; i < 4; i++) begin
                r[i] = rot[i];
                v[i] = vec[i];
                // conjugate kept wide: negating the most negative code is exact
                rc[i] = (i == 0) ? r[i] : -r[i];
            end
            hamilton(r, v, m, clipped);
            hamilton(m, rc, o, clipped);
            for (int i = 0; i < 4; i++)
                want.c[i] = comp_t'(o[i]);
            want.sat = clipped;
            expected_q.push_back(want);
        endfunction

        task check_result(rotated_t got);
            rotated_t want;
            string names[4];
            names = '{"w", "x", "y", "z"};
            if (expected_q.size() == 0) begin
                report($sformatf("result with nothing expected: w=%0d x=%0d y=%0d z=%0d",
                                 got.c[0], got.c[1], got.c[2], got.c[3]));
                return;
            end
            want = expected_q.pop_front();
            for (int i = 0; i < 4; i++)
                if (got.c[i] !== want.c[i])
                    report($sformatf("out_%s mismatch: got %0d, expected %0d",
                                     names[i], got.c[i], want.c[i]));
            if (got.sat !== want.sat)
                report($sformatf("saturated mismatch: got %b, expected %b",
                                 got.sat, want.sat));
        endtask
    endclass

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  start = 1'b0;
    logic  busy;
    comp_t i_rot_w = '0, i_rot_x = '0, i_rot_y = '0, i_rot_z = '0;
    comp_t i_vec_w = '0, i_vec_x = '0, i_vec_y = '0, i_vec_z = '0;
    logic  o_valid;
    comp_t o_out_w, o_out_x, o_out_y, o_out_z;
    logic  o_saturated;

    rotation_scoreboard sb = new();

    quaternion_vector_rotation dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_rot_w     (i_rot_w),
        .i_rot_x     (i_rot_x),
        .i_rot_y     (i_rot_y),
        .i_rot_z     (i_rot_z),
        .i_vec_w     (i_vec_w),
        .i_vec_x     (i_vec_x),
        .i_vec_y     (i_vec_y),
        .i_vec_z     (i_vec_z),
        .o_valid     (o_valid),
        .o_out_w     (o_out_w),
        .o_out_x     (o_out_x),
        .o_out_y     (o_out_y),
        .o_out_z     (o_out_z),
        .o_saturated (o_saturated)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Monitor: sees pre-edge values, so the item taken and the result shown
    // are exactly what the block saw at this edge.
    always @(posedge i_clk) begin
        rotated_t got;
        if (i_rst_n === 1'b1 && start === 1'b1 && busy === 1'b0)
            sb.note_item('{i_rot_w, i_rot_x, i_rot_y, i_rot_z},
                         '{i_vec_w, i_vec_x, i_vec_y, i_vec_z});
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            got.c[0] = o_out_w;
            got.c[1] = o_out_x;
            got.c[2] = o_out_y;
            got.c[3] = o_out_z;
            got.sat  = o_saturated;
            sb.check_result(got);
        end
    end

    // Idle cycles before an item: mostly none, some short, a few long.
    function int idle_len();
        int roll;
        roll = $urandom_range(99);
        if (roll < 55)
            return 0;
        else if (roll < 85)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 15);
        else
            return $urandom_range(20, 80);
    endfunction

    // One component drawn in a given style:
    //   0 any code, 1 corner codes, 2 within +/-1.0 (rotor-like magnitudes)
    function comp_t pick(int style);
        int corners[8];
        corners = '{-32768, -32767, -16384, -1, 0, 1, 16384, 32767};
        case (style)
            0: return comp_t'($urandom);
            1: return comp_t'(corners[$urandom_range(7)]);
            default: return comp_t'(int'($urandom_range(2 * ONE)) - ONE);
        endcase
    endfunction

    // Present one item after the given number of idle cycles and hold it
    // until the block takes it. Returns on the accepting edge, so the next
    // call can follow back to back.
    task send_item(input comp_t rw, rx, ry, rz, vw, vx, vy, vz, input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start   <= 1'b1;
        i_rot_w <= rw;
        i_rot_x <= rx;
        i_rot_y <= ry;
        i_rot_z <= rz;
        i_vec_w <= vw;
        i_vec_x <= vx;
        i_vec_y <= vy;
        i_vec_z <= vz;
        do
            @(posedge i_clk);
        while (busy !== 1'b0);
    endtask

    // Sender holds off until every outstanding result has come back. One
    // edge first, so the item taken on the last edge is already queued.
    task drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_q.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        int style, gap;
        comp_t r[4], v[4];

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed items
        // identity rotor
        send_item(ONE, 0, 0, 0, 0, ONE, -ONE, 8192, 0);
        // quarter turn about z
        send_item(COS45, 0, 0, COS45, 0, ONE, 0, 0, 0);
        // half turn about x
        send_item(0, ONE, 0, 0, 0, 1000, 2000, -3000, 1);
        // zero rotor wipes everything
        send_item(0, 0, 0, 0, 0, 32767, -32768, 1, 0);
        // all components at the top code
        send_item(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 0);
        // all components at the bottom code
        send_item(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, 2);
        // alternating extremes, clips in the middle product
        send_item(-32768, 32767, -32768, 32767, 32767, -32768, 32767, -32768, 0);
        // rotor of -1
        send_item(-ONE, 0, 0, 0, 0, -32768, 32767, -1, 0);
        // operand with a scalar part
        send_item(COS45, COS45, 0, 0, ONE, 100, -200, 300, 0);
        // exact half LSB sums: round toward +inf on both signs
        send_item(1, 0, 0, 0, 8192, 8192, -8192, -8191, 0);
        send_item(ONE, 0, 0, 0, -1, 1, -1, 1, 3);
        // |r|^2 = 2: middle product in range, final result clips
        send_item(ROOT2, 0, 0, 0, 0, 20000, -20000, 10000, 0);
        // most negative code times itself
        send_item(0, 0, 0, -32768, 0, 0, 0, -32768, 0);
        // single LSB values
        send_item(1, -1, 1, -1, -1, 1, -1, 1, 0);
        send_item(0, 0, 32767, 0, -32768, 0, 0, 0, 0);
        // third of a turn about the diagonal
        send_item(8192, 8192, 8192, 8192, 0, ONE, 0, 0, 1);
        // conjugate of the bottom code in each vector component
        send_item(ONE, -32768, -32768, -32768, 0, ONE, ONE, ONE, 0);
        drain();

        // random items: mostly rotor-like pure vectors, the rest anything
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 2)
                drain();
            style = $urandom_range(99);
            style = (style < 65) ? 2 : (style < 88) ? 0 : 1;
            for (int i = 0; i < 4; i++) begin
                r[i] = pick(style);
                v[i] = pick($urandom_range(2));
            end
            // pure vector most of the time
            if ($urandom_range(99) < 75)
                v[0] = '0;
            // stretches of back-to-back items
            gap = ((n / 64) % 3 == 0) ? 0 : idle_len();
            send_item(r[0], r[1], r[2], r[3], v[0], v[1], v[2], v[3], gap);
        end
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // run limit, far beyond the slowest correct run
    initial begin
        #2000000;
        $display("status: fail");
        $finish;
    end

endmodule
